>>> design/fti_pkg.sv
// shared constants, types and breakpoint helpers for the fog table interpolator
package fti_pkg;

  localparam int FRACTION_BITS     = 8;
  localparam int OOW_FRACTION_BITS = 24;

  localparam int OOW_W       = 32;
  localparam int MAG_W       = OOW_W - 1;
  localparam int LEVEL_W     = 16;
  localparam int INDEX_W     = 6;
  localparam int FRAC_OUT_W  = 9;
  localparam int ENTRY_W     = 8;
  localparam int TABLE_WORDS = 8;
  localparam int WORD_W      = 64;
  localparam int WORD_SEL_W  = 3;
  localparam int CFG_IDX_W   = 4;
  localparam int BIT_SEL_W   = 3;

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(63);

  // breakpoint exponent and multiplier fields
  localparam int EXP_W   = 5;
  localparam int MUL_W   = 4;
  localparam int MAX_EXP = 3 + (63 >> 2);
  localparam int SHIFT_W = MAG_W + MAX_EXP;

  // oow at or below FAR_MAX sits at or beyond the last breakpoint
  localparam longint FAR_MAX  = (longint'(5) << OOW_FRACTION_BITS) >> MAX_EXP;
  localparam longint NEAR_MIN = longint'(1) << OOW_FRACTION_BITS;

  // divider widths
  localparam int X_W   = OOW_FRACTION_BITS + 3;
  localparam int NUM_W = X_W + MUL_W;
  localparam int DEN_W = X_W + 1;
  localparam int Q_W   = FRACTION_BITS + 1;

  localparam int PROD_W = (ENTRY_W + 1) + (Q_W + 1);
  localparam int SUM_A  = ENTRY_W + FRACTION_BITS + 2;
  localparam int SUM_B  = (PROD_W + 1 > LEVEL_W) ? PROD_W + 1 : LEVEL_W;
  localparam int SUM_W  = (SUM_A > SUM_B) ? SUM_A : SUM_B;

  localparam int STEP_W = 5;

  localparam logic [FRAC_OUT_W-1:0] FRAC_ONE = FRAC_OUT_W'(1 << FRACTION_BITS);

  typedef struct packed {
    logic                 load;
    logic                 srch_step;
    logic [BIT_SEL_W-1:0] srch_bit;
    logic                 prep;
    logic                 div_step;
    logic                 div_first;
    logic                 rd_lo;
    logic                 rd_hi;
    logic                 mul;
    logic                 fin;
  } fti_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_busy;
  } fti_sts_t;

  function automatic logic [EXP_W-1:0] bp_exp(input logic [INDEX_W-1:0] i);
    return EXP_W'(3) + EXP_W'(i[5:2]);
  endfunction

  function automatic logic [MUL_W-1:0] bp_mul(input logic [INDEX_W-1:0] i);
    return MUL_W'(8) - MUL_W'(i[1:0]);
  endfunction

endpackage

>>> design/fog_table_interpolator.sv
// Fog table interpolator: maps a Q8.24 reciprocal depth to a blended fog level from a
// 64-entry byte table held in eight 64-bit registers. One item is processed at a time:
// a positive in-range oow gets a 6-step breakpoint search through one shared
// comparator, then a restoring divider that produces one fraction bit per cycle,
// then two table reads, a multiply and the result load; non-positive, near and far
// inputs skip search and divide. The output register lets the next item be taken
// while a result waits. Table registers are written through the cfg port, one word
// per transfer; the user must write them only while idle (not enforced by the block).
module fog_table_interpolator import fti_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [OOW_W-1:0] in_oow,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [LEVEL_W-1:0]      out_fog_level,
  output logic [INDEX_W-1:0]      out_entry_index,
  output logic [FRAC_OUT_W-1:0]   out_fraction,
  output logic                    out_sample_valid,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [WORD_W-1:0]       cfg_data
);

  fti_cmd_t cmd;
  fti_sts_t sts;

  fti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fti_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_oow           (in_oow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fog_level    (out_fog_level),
    .out_entry_index  (out_entry_index),
    .out_fraction     (out_fraction),
    .out_sample_valid (out_sample_valid)
  );

endmodule

>>> design/fti_ctrl.sv
// controller sequencing search, divide, table read and result load
module fti_ctrl import fti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fti_sts_t sts,
  output fti_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RDLO  = 4'd5;
  localparam logic [3:0] S_RDHI  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.srch_bit  = cnt_r[BIT_SEL_W-1:0];
    cmd.div_first = (cnt_r == STEP_W'(FRACTION_BITS));
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.skip) begin
          state_nxt = S_RDLO;
        end else begin
          cnt_nxt   = STEP_W'(INDEX_W - 1);
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.srch_step = 1'b1;
        cnt_nxt       = cnt_r - STEP_W'(1);
        if (cnt_r == '0) state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = STEP_W'(FRACTION_BITS);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - STEP_W'(1);
        if (cnt_r == '0) state_nxt = S_RDLO;
      end
      S_RDLO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_RDHI;
      end
      S_RDHI: begin
        cmd.rd_hi = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> design/fti_dp.sv
// datapath: table words, breakpoint search, fraction divider, blend and output register
module fti_dp import fti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fti_cmd_t                 cmd,
  output fti_sts_t                 sts,
  input  logic signed [OOW_W-1:0]  in_oow,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [WORD_W-1:0]        cfg_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LEVEL_W-1:0]       out_fog_level,
  output logic [INDEX_W-1:0]       out_entry_index,
  output logic [FRAC_OUT_W-1:0]    out_fraction,
  output logic                     out_sample_valid
);

  logic [WORD_W-1:0]         words_r [TABLE_WORDS];
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic                      skip_r;
  logic [INDEX_W-1:0]        lo_r;
  logic [Q_W-1:0]            quot_r;
  logic [NUM_W-1:0]          rem_r;
  logic [DEN_W-1:0]          den_r;
  logic [ENTRY_W-1:0]        lower_r, upper_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic                      out_valid_r;
  logic [LEVEL_W-1:0]        level_r;
  logic [INDEX_W-1:0]        idx_r;
  logic [FRAC_OUT_W-1:0]     frac_r;
  logic                      sv_r;

  logic                      in_neg, in_far, in_near;
  logic [MAG_W-1:0]          in_mag;
  logic [INDEX_W-1:0]        cand, lo_nx, rd_idx;
  logic [SHIFT_W-1:0]        cand_sh, cand_thr, lo_sh;
  logic [X_W-1:0]            a_val, ml_val, diff_val;
  logic [NUM_W-1:0]          numer, rem_sh, den_ext;
  logic [DEN_W-1:0]          den_val;
  logic                      q_bit;
  logic [ENTRY_W-1:0]        rd_byte;
  logic [WORD_W-1:0]         rd_word;
  logic signed [ENTRY_W:0]   ent_diff;
  logic signed [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0]        level_val;

  assign cfg_ready = 1'b1;

  // input classification
  assign in_mag  = in_oow[MAG_W-1:0];
  assign in_neg  = in_oow[OOW_W-1] || (in_oow == '0);
  assign in_far  = (in_mag <= MAG_W'(FAR_MAX));
  assign in_near = (in_mag >= MAG_W'(NEAR_MIN));

  // one breakpoint compare per search step, msb of the index first
  assign cand     = lo_r | (INDEX_W'(1) << cmd.srch_bit);
  assign cand_sh  = SHIFT_W'(mag_r) << bp_exp(cand);
  assign cand_thr = SHIFT_W'(bp_mul(cand)) << OOW_FRACTION_BITS;

  // numerator and denominator of the weight for interval lo..lo+1
  assign lo_nx    = lo_r + INDEX_W'(1);
  assign lo_sh    = SHIFT_W'(mag_r) << bp_exp(lo_r);
  assign a_val    = lo_sh[X_W-1:0];
  assign ml_val   = X_W'(bp_mul(lo_r)) << OOW_FRACTION_BITS;
  assign diff_val = ml_val - a_val;
  assign numer    = NUM_W'(bp_mul(lo_nx)) * NUM_W'(diff_val);
  assign den_val  = (lo_r[1:0] == 2'd3) ? {a_val, 1'b0} : {1'b0, a_val};

  // restoring divider, one quotient bit per step
  assign rem_sh  = cmd.div_first ? rem_r : {rem_r[NUM_W-2:0], 1'b0};
  assign den_ext = NUM_W'(den_r);
  assign q_bit   = (rem_sh >= den_ext);

  // table read, one byte per cycle
  assign rd_idx  = cmd.rd_hi ? lo_nx : lo_r;
  assign rd_word = words_r[rd_idx[INDEX_W-1:BIT_SEL_W]];
  assign rd_byte = rd_word[rd_idx[BIT_SEL_W-1:0]*ENTRY_W +: ENTRY_W];

  assign ent_diff = $signed({1'b0, upper_r}) - $signed({1'b0, lower_r});

  assign sum = $signed(SUM_W'({lower_r, {FRACTION_BITS{1'b0}}})) + SUM_W'(prod_r);
  assign level_val = (neg_r || sum[SUM_W-1]) ? '0 : sum[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < TABLE_WORDS; w++) words_r[w] <= '0;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(TABLE_WORDS))) begin
      words_r[cfg_index[WORD_SEL_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= in_mag;
      neg_r  <= in_neg;
      skip_r <= in_neg || in_far || in_near;
      lo_r   <= (in_far && !in_neg) ? LAST_INDEX : '0;
      quot_r <= '0;
    end else if (cmd.srch_step) begin
      if (cand_sh < cand_thr) lo_r <= cand;
    end else if (cmd.prep) begin
      rem_r  <= numer;
      den_r  <= den_val;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? rem_sh - den_ext : rem_sh;
      quot_r <= {quot_r[Q_W-2:0], q_bit};
    end
    if (cmd.rd_lo) lower_r <= rd_byte;
    if (cmd.rd_hi) upper_r <= rd_byte;
    if (cmd.mul) prod_r <= ent_diff * $signed({1'b0, quot_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      level_r <= level_val;
      idx_r   <= neg_r ? '0 : lo_r;
      frac_r  <= neg_r ? '0 : FRAC_OUT_W'(quot_r);
      sv_r    <= !neg_r;
    end
  end

  assign sts.skip     = skip_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_fog_level    = level_r;
  assign out_entry_index  = idx_r;
  assign out_fraction     = frac_r;
  assign out_sample_valid = sv_r;

endmodule

>>> design/fti_checker.sv
// port-level checks for the fog table interpolator and their bind
module fti_checker import fti_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [LEVEL_W-1:0]      out_fog_level,
  input logic [INDEX_W-1:0]      out_entry_index,
  input logic [FRAC_OUT_W-1:0]   out_fraction,
  input logic                    out_sample_valid
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fog_level) &&
      $stable(out_entry_index) && $stable(out_fraction) && $stable(out_sample_valid))
    else $error("result changed while stalled");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // rejected samples carry zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_sample_valid |->
      out_fog_level == '0 && out_entry_index == '0 && out_fraction == '0)
    else $error("rejected sample with nonzero fields");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= FRAC_ONE)
    else $error("fraction above one");

  // the last entry is used alone
  a_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_index == LAST_INDEX |-> out_fraction == '0)
    else $error("nonzero fraction at last entry");

endmodule

bind fog_table_interpolator fti_checker u_fti_checker (.*);
